// ===== hw/rtl/sml_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sml_pkg
// Shared types and constants of the load-and-step machine.
// ----------------------------------------------------------------------------
package sml_pkg;

   localparam int MEM_BYTES_DEF = 256;
   localparam int REG_COUNT     = 16;
   localparam int REG_AW        = 4;
   localparam int CSR_AW        = 3;

   localparam logic [3:0] OP_LOAD_MEM = 4'h1;
   localparam logic [3:0] OP_LOAD_IMM = 4'h2;
   localparam logic [3:0] OP_STORE    = 4'h3;
   localparam logic [3:0] OP_MOVE     = 4'h4;
   localparam logic [3:0] OP_ADD_INT  = 4'h5;
   localparam logic [3:0] OP_ADD_FIX  = 4'h6;
   localparam logic [3:0] OP_JUMP     = 4'hB;
   localparam logic [3:0] OP_HALT     = 4'hC;

   localparam logic [1:0] ST_ACCEPTED = 2'd0;
   localparam logic [1:0] ST_HALTED   = 2'd1;
   localparam logic [1:0] ST_MEM_FULL = 2'd2;
   localparam logic [1:0] ST_IGNORED  = 2'd3;

   localparam logic CSR_IDX_START = 1'b0;
   localparam logic CSR_IDX_EXEC  = 1'b1;

   localparam logic [7:0] START_RESET   = 8'd0;
   localparam logic       EXEC_EN_RESET = 1'b1;

   typedef struct packed {
      logic       en;
      logic [7:0] addr;
      logic [7:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic              en;
      logic [REG_AW-1:0] addr;
      logic [7:0]        data;
   } reg_wr_type;

endpackage

// ===== hw/rtl/sml_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sml_req_if / sml_rsp_if
// Request and response channels of the load-and-step machine.
// ----------------------------------------------------------------------------
interface sml_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] instruction_word;

   modport source (output valid, output instruction_word, input ready);
   modport sink (input valid, input instruction_word, output ready);
endinterface

interface sml_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] pointer_after;
   logic       output_valid;
   logic [7:0] output_value;

   modport source (output valid, output status, output pointer_after,
                   output output_valid, output output_value, input ready);
   modport sink (input valid, input status, input pointer_after,
                 input output_valid, input output_value, output ready);
endinterface

// ===== hw/rtl/sml_main_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sml_main_mem
// Byte memory split into even and odd banks, one read with a registered result.
// ----------------------------------------------------------------------------
module sml_main_mem #(
   parameter int MEM_BYTES = sml_pkg::MEM_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  sml_pkg::mem_wr_type wr0,
   input  sml_pkg::mem_wr_type wr1,
   input  logic               rd_en,
   input  logic [7:0]         rd_addr,
   output logic [7:0]         rd_data
);
   import sml_pkg::*;

   localparam int BANK_DEPTH = (MEM_BYTES + 1) / 2;
   localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   logic [7:0]            bank_mem [2][BANK_DEPTH];
   logic [BANK_DEPTH-1:0] vld_ff [2];
   logic [7:0]            rd_ff [2];
   logic                  rd_vld_ff [2];
   logic                  rd_sel_ff;
   logic                  wen [2];
   logic [BANK_AW-1:0]    widx [2];
   logic [7:0]            wdata [2];
   logic [BANK_AW-1:0]    ridx;

   assign ridx = rd_addr[BANK_AW:1];

   for (genvar b = 0; b < 2; b++) begin : g_bank
      always_comb begin
         wen[b]   = 1'b0;
         widx[b]  = wr0.addr[BANK_AW:1];
         wdata[b] = wr0.data;
         if (wr0.en && (wr0.addr[0] == 1'(b))) begin
            wen[b] = 1'b1;
         end else if (wr1.en && (wr1.addr[0] == 1'(b))) begin
            wen[b]   = 1'b1;
            widx[b]  = wr1.addr[BANK_AW:1];
            wdata[b] = wr1.data;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[b] <= '0;
         end else if (wen[b]) begin
            vld_ff[b][widx[b]] <= 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (wen[b]) begin
            bank_mem[b][widx[b]] <= wdata[b];
         end
         if (rd_en && (rd_addr[0] == 1'(b))) begin
            rd_ff[b]     <= bank_mem[b][ridx];
            rd_vld_ff[b] <= vld_ff[b][ridx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_sel_ff <= rd_addr[0];
      end
   end

   assign rd_data = rd_vld_ff[rd_sel_ff] ? rd_ff[rd_sel_ff] : 8'd0;

endmodule

// ===== hw/rtl/sml_reg_file.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sml_reg_file
// Sixteen 8-bit registers with two registered reads and one write.
// ----------------------------------------------------------------------------
module sml_reg_file (
   input  logic                       clock,
   input  logic                       reset,
   input  sml_pkg::reg_wr_type        wr,
   input  logic                       rd_en,
   input  logic [sml_pkg::REG_AW-1:0] rd_addr_a,
   input  logic [sml_pkg::REG_AW-1:0] rd_addr_b,
   output logic [7:0]                 rd_data_a,
   output logic [7:0]                 rd_data_b
);
   import sml_pkg::*;

   logic [7:0]           reg_mem [REG_COUNT];
   logic [REG_COUNT-1:0] vld_ff;
   logic [7:0]           rd_a_ff;
   logic [7:0]           rd_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr.en) begin
         vld_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         reg_mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_a_ff <= vld_ff[rd_addr_a] ? reg_mem[rd_addr_a] : 8'd0;
         rd_b_ff <= vld_ff[rd_addr_b] ? reg_mem[rd_addr_b] : 8'd0;
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== hw/rtl/simple_machine_load_and_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simple_machine_load_and_step
// Loads 16-bit instruction words into byte memory and executes each one.
// ----------------------------------------------------------------------------
// Each request has an accept cycle and an execute stage: in the accept cycle the
// two instruction bytes are written to the even and odd memory banks while the
// register file and, for a memory load, the addressed byte are read; in the
// execute stage the result is written back to the register file or memory, the
// load pointer is updated and the response is registered. The request side is
// ready again once execute completes, so a new request is taken only after the
// last has executed; execute waits while an older response is held in the output
// register, though such a response alone does not hold up an accept. Memory and
// registers read as zero after reset via per-entry valid bits; no clearing pass.
module simple_machine_load_and_step #(
   parameter int MEM_BYTES = sml_pkg::MEM_BYTES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   sml_req_if.sink                    req_bus,
   sml_rsp_if.source                  rsp_bus,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [sml_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   import sml_pkg::*;

   localparam logic [9:0] MEM_LIMIT = 10'(MEM_BYTES);

   logic [8:0]  ptr_ff, ptr_in;
   logic        stopped_ff, stopped_in;
   logic [7:0]  start_addr_ff;
   logic        exec_en_ff;
   logic        exec_valid_ff;

   logic [1:0]  ex_status_ff;
   logic        ex_run_ff;
   logic [3:0]  ex_op_ff;
   logic [3:0]  ex_na_ff;
   logic [3:0]  ex_nc_ff;
   logic [7:0]  ex_xy_ff;
   logic [7:0]  ex_hi_ff;
   logic        ex_fwd_hi_ff;
   logic        ex_fwd_lo_ff;
   logic        ex_xy_fits_ff;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [7:0]  rsp_ptr_ff;
   logic        rsp_ovalid_ff;
   logic [7:0]  rsp_ovalue_ff;

   logic        req_fire;
   logic        ex_done;
   logic        csr_wr;
   logic [15:0] word;
   logic [3:0]  op, na, nb, nc;
   logic [7:0]  xy;
   logic [9:0]  ptr_plus1;
   logic        mem_full;
   logic        xy_fits;
   logic [1:0]  pre_status;
   logic        write_ok;
   logic [7:0]  ptr_lo_next;

   mem_wr_type  inst_hi_wr, inst_lo_wr, store_wr, mem_wr0;
   reg_wr_type  reg_wr, reg_wr_gated;
   logic        mem_rd_en;
   logic [7:0]  mem_rd_data;
   logic [3:0]  rf_addr_a, rf_addr_b;
   logic [7:0]  rf_data_a, rf_data_b;

   logic [7:0]  mem_byte;
   logic [8:0]  ptr_plus2;
   logic [8:0]  jump_target;
   logic        jump_fits;
   logic [1:0]  ex_status;
   logic        out_vld;
   logic [7:0]  out_val;

   // Accept stage.
   assign req_bus.ready = !exec_valid_ff;
   assign req_fire      = req_bus.valid && !exec_valid_ff;
   assign word          = req_bus.instruction_word;
   assign op            = word[15:12];
   assign na            = word[11:8];
   assign nb            = word[7:4];
   assign nc            = word[3:0];
   assign xy            = word[7:0];
   assign ptr_plus1     = {1'b0, ptr_ff} + 10'd1;
   assign mem_full      = ptr_plus1 >= MEM_LIMIT;
   assign xy_fits       = {2'b00, xy} < MEM_LIMIT;
   assign ptr_lo_next   = ptr_ff[7:0] + 8'd1;

   always_comb begin
      if (stopped_ff) begin
         pre_status = ST_IGNORED;
      end else if (mem_full) begin
         pre_status = ST_MEM_FULL;
      end else begin
         pre_status = ST_ACCEPTED;
      end
   end

   assign write_ok   = req_fire && (pre_status == ST_ACCEPTED);
   assign inst_hi_wr = '{en: write_ok, addr: ptr_ff[7:0], data: word[15:8]};
   assign inst_lo_wr = '{en: write_ok, addr: ptr_lo_next, data: xy};
   assign mem_rd_en  = req_fire && (op == OP_LOAD_MEM) && xy_fits;
   assign rf_addr_a  = ((op == OP_MOVE) || (op == OP_ADD_INT) || (op == OP_ADD_FIX)) ? nb : na;
   assign rf_addr_b  = (op == OP_JUMP) ? 4'd0 : nc;
   assign mem_wr0    = (store_wr.en && ex_done) ? store_wr : inst_hi_wr;

   sml_main_mem #(
      .MEM_BYTES (MEM_BYTES)
   ) u_main_mem (
      .clock   (clock),
      .reset   (reset),
      .wr0     (mem_wr0),
      .wr1     (inst_lo_wr),
      .rd_en   (mem_rd_en),
      .rd_addr (xy),
      .rd_data (mem_rd_data)
   );

   sml_reg_file u_reg_file (
      .clock     (clock),
      .reset     (reset),
      .wr        (reg_wr_gated),
      .rd_en     (req_fire),
      .rd_addr_a (rf_addr_a),
      .rd_addr_b (rf_addr_b),
      .rd_data_a (rf_data_a),
      .rd_data_b (rf_data_b)
   );

   // Execute stage.
   assign ex_done     = exec_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign mem_byte    = ex_fwd_lo_ff ? ex_xy_ff : (ex_fwd_hi_ff ? ex_hi_ff : mem_rd_data);
   assign ptr_plus2   = ptr_ff + 9'd2;
   assign jump_target = {ex_xy_ff, 1'b0};
   assign jump_fits   = {1'b0, jump_target} < MEM_LIMIT;

   always_comb begin
      ptr_in     = ptr_ff;
      stopped_in = stopped_ff;
      ex_status  = ex_status_ff;
      store_wr   = '0;
      reg_wr     = '0;
      out_vld    = 1'b0;
      out_val    = 8'd0;
      if (ex_status_ff != ST_ACCEPTED) begin
         stopped_in = 1'b1;
      end else if (!ex_run_ff) begin
         ptr_in = ptr_plus2;
      end else begin
         case (ex_op_ff)
            OP_LOAD_MEM: begin
               ptr_in = ptr_plus2;
               if (ex_xy_fits_ff) begin
                  reg_wr = '{en: 1'b1, addr: ex_na_ff, data: mem_byte};
               end
            end
            OP_LOAD_IMM: begin
               ptr_in = ptr_plus2;
               reg_wr = '{en: 1'b1, addr: ex_na_ff, data: ex_xy_ff};
            end
            OP_STORE: begin
               ptr_in = ptr_plus2;
               if (ex_xy_fits_ff) begin
                  store_wr = '{en: 1'b1, addr: ex_xy_ff, data: rf_data_a};
                  if (ex_xy_ff == 8'd0) begin
                     out_vld = 1'b1;
                     out_val = rf_data_a;
                  end
               end
            end
            OP_MOVE: begin
               ptr_in = ptr_plus2;
               reg_wr = '{en: 1'b1, addr: ex_nc_ff, data: rf_data_a};
            end
            OP_ADD_INT, OP_ADD_FIX: begin
               ptr_in = ptr_plus2;
               reg_wr = '{en: 1'b1, addr: ex_na_ff, data: rf_data_a + rf_data_b};
            end
            OP_JUMP: begin
               if ((rf_data_a == rf_data_b) && jump_fits) begin
                  ptr_in = jump_target;
               end else begin
                  ptr_in = ptr_plus2;
               end
            end
            OP_HALT: begin
               ex_status  = ST_HALTED;
               stopped_in = 1'b1;
            end
            default: begin
               ptr_in = ptr_ff;
            end
         endcase
      end
   end

   always_comb begin
      reg_wr_gated    = reg_wr;
      reg_wr_gated.en = reg_wr.en && ex_done;
   end

   // Control state and configuration registers.
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_EXEC) ? {31'd0, exec_en_ff}
                                                      : {24'd0, start_addr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff        <= {1'b0, START_RESET};
         stopped_ff    <= 1'b0;
         start_addr_ff <= START_RESET;
         exec_en_ff    <= EXEC_EN_RESET;
         exec_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr && (csr_paddr[2] == CSR_IDX_START)) begin
            start_addr_ff <= csr_pwdata[7:0];
            ptr_ff        <= {1'b0, csr_pwdata[7:0]};
         end else if (ex_done) begin
            ptr_ff <= ptr_in;
         end
         if (csr_wr && (csr_paddr[2] == CSR_IDX_EXEC)) begin
            exec_en_ff <= csr_pwdata[0];
         end
         if (ex_done) begin
            stopped_ff <= stopped_in;
         end
         if (req_fire) begin
            exec_valid_ff <= 1'b1;
         end else if (ex_done) begin
            exec_valid_ff <= 1'b0;
         end
         if (ex_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ex_status_ff  <= pre_status;
         ex_run_ff     <= exec_en_ff;
         ex_op_ff      <= op;
         ex_na_ff      <= na;
         ex_nc_ff      <= nc;
         ex_xy_ff      <= xy;
         ex_hi_ff      <= word[15:8];
         ex_fwd_hi_ff  <= xy == ptr_ff[7:0];
         ex_fwd_lo_ff  <= xy == ptr_lo_next;
         ex_xy_fits_ff <= xy_fits;
      end
      if (ex_done) begin
         rsp_status_ff <= ex_status;
         rsp_ptr_ff    <= ptr_in[7:0];
         rsp_ovalid_ff <= out_vld;
         rsp_ovalue_ff <= out_val;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.pointer_after = rsp_ptr_ff;
   assign rsp_bus.output_valid  = rsp_ovalid_ff;
   assign rsp_bus.output_value  = rsp_ovalue_ff;

endmodule

// ===== hw/rtl/sml_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sml_checker
// Port-level checks of the load-and-step machine, bound to the top level.
// ----------------------------------------------------------------------------
module sml_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_pointer_after,
   input logic       rsp_output_valid,
   input logic [7:0] rsp_output_value
);
   import sml_pkg::*;

   logic       req_fire;
   logic       rsp_fire;
   logic       seen_stop_ff, seen_stop_in;
   logic [1:0] pending_ff, pending_in;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      seen_stop_in = seen_stop_ff;
      if (rsp_fire && ((rsp_status == ST_HALTED) || (rsp_status == ST_MEM_FULL))) begin
         seen_stop_in = 1'b1;
      end
      pending_in = pending_ff + 2'(req_fire) - 2'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_stop_ff <= 1'b0;
         pending_ff   <= 2'd0;
      end else begin
         seen_stop_ff <= seen_stop_in;
         pending_ff   <= pending_in;
      end
   end

   a_ignored_after_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_stop_ff |-> rsp_status == ST_IGNORED)
      else $error("response after a stop is not marked ignored");

   a_output_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_output_valid |-> rsp_status == ST_ACCEPTED)
      else $error("output reported on a request that did not execute");

   a_output_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_output_valid |-> rsp_output_value == 8'd0)
      else $error("output value not zero without an output");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response without an outstanding request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_pointer_after) && $stable(rsp_output_valid)
         && $stable(rsp_output_value))
      else $error("stalled response changed");

endmodule

bind simple_machine_load_and_step sml_checker u_sml_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_status        (rsp_bus.status),
   .rsp_pointer_after (rsp_bus.pointer_after),
   .rsp_output_valid  (rsp_bus.output_valid),
   .rsp_output_value  (rsp_bus.output_value)
);

// ===== verif/tb_simple_machine_load_and_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_simple_machine_load_and_step
// Self-checking bench for the load-and-step instruction machine.
// ----------------------------------------------------------------------------
// A short table of hand-picked requests and register writes runs first. It is
// followed by several random phases, each with its own start address and
// execute setting. A behavioral copy of the machine inside the bench predicts
// every response that the table does not give, and a monitor compares each
// response field by field in order. The run ends on purpose with a halt or a
// memory-full stop, since only the single reset can clear a stop.
// ----------------------------------------------------------------------------
module tb_simple_machine_load_and_step;
   import sml_pkg::*;

   localparam int MEM_BYTES      = MEM_BYTES_DEF;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASES         = 8;
   localparam int PHASE_REQUESTS = 220;
   localparam int LONG_HOLD      = 80;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] pointer_after;
      logic       output_valid;
      logic [7:0] output_value;
   } outcome_type;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic         csr_idx;
      logic [15:0]  value;
      logic         typed;
      outcome_type  want;
   } plan_row_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CSR_AW-1:0]   csr_paddr;
   logic [31:0]         csr_pwdata;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   sml_req_if req_bus ();
   sml_rsp_if rsp_bus ();

   simple_machine_load_and_step dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Machine state as the bench believes it to be.
   logic [7:0] mach_mem [MEM_BYTES];
   logic [7:0] mach_regs [REG_COUNT];
   logic [8:0] mach_ptr;
   logic       mach_stopped;
   logic       mach_exec;

   outcome_type  pending_outcomes [$];
   plan_row_type plan [$];
   outcome_type  head;

   int error_count = 0;
   int requests_sent = 0;
   int csr_writes = 0;
   int zero_stores = 0;
   int status_seen [4] = '{0, 0, 0, 0};
   int idle_pct = 21;
   int long_holds_asked = 0;
   int quiet_cycles = 0;

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= 40)
         $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   function automatic void reset_machine();
      for (int i = 0; i < MEM_BYTES; i++)
         mach_mem[i] = 8'h00;
      for (int i = 0; i < REG_COUNT; i++)
         mach_regs[i] = 8'h00;
      mach_exec = EXEC_EN_RESET;
      mach_ptr = {1'b0, START_RESET};
      mach_stopped = 1'b0;
   endfunction

   function automatic outcome_type execute_word(input logic [15:0] w);
      outcome_type r;
      logic [3:0]  op;
      logic [3:0]  na;
      logic [3:0]  nb;
      logic [3:0]  nc;
      logic [7:0]  xy;
      logic [9:0]  nxt;
      logic [9:0]  target;
      op = w[15:12];
      na = w[11:8];
      nb = w[7:4];
      nc = w[3:0];
      xy = w[7:0];
      r = '0;
      r.status = ST_ACCEPTED;
      nxt = {1'b0, mach_ptr} + 10'd2;
      target = {1'b0, xy, 1'b0};
      if (mach_stopped) begin
         r.status = ST_IGNORED;
         nxt = {1'b0, mach_ptr};
      end else if (int'(mach_ptr) + 1 >= MEM_BYTES) begin
         r.status = ST_MEM_FULL;
         mach_stopped = 1'b1;
         nxt = {1'b0, mach_ptr};
      end else begin
         mach_mem[mach_ptr[7:0]] = w[15:8];
         mach_mem[mach_ptr[7:0] + 8'd1] = xy;
         if (mach_exec) begin
            case (op)
               OP_LOAD_MEM: begin
                  if (int'(xy) < MEM_BYTES)
                     mach_regs[na] = mach_mem[xy];
               end
               OP_LOAD_IMM: mach_regs[na] = xy;
               OP_STORE: begin
                  if (int'(xy) < MEM_BYTES) begin
                     mach_mem[xy] = mach_regs[na];
                     if (xy == 8'h00) begin
                        r.output_valid = 1'b1;
                        r.output_value = mach_regs[na];
                     end
                  end
               end
               OP_MOVE: mach_regs[nc] = mach_regs[nb];
               OP_ADD_INT, OP_ADD_FIX: mach_regs[na] = mach_regs[nb] + mach_regs[nc];
               OP_JUMP: begin
                  if (mach_regs[na] == mach_regs[0] && int'(target) < MEM_BYTES)
                     nxt = target;
               end
               OP_HALT: begin
                  r.status = ST_HALTED;
                  mach_stopped = 1'b1;
                  nxt = {1'b0, mach_ptr};
               end
               default: nxt = {1'b0, mach_ptr};
            endcase
         end
      end
      mach_ptr = nxt[8:0];
      r.pointer_after = nxt[7:0];
      return r;
   endfunction

   function automatic logic [15:0] pick_word();
      logic [3:0]  op;
      logic [3:0]  ra;
      logic [7:0]  xy;
      logic [15:0] w;
      logic        defined;
      int          r;
      ra = 4'($urandom_range(0, 15));
      xy = 8'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (mach_exec && mach_ptr >= 9'h0F0) begin
         xy = 8'($urandom_range(0, 8'h77));
         return {OP_JUMP, 4'h0, xy};
      end
      if (r < 10) begin
         op = OP_LOAD_MEM;
      end else if (r < 26) begin
         op = OP_LOAD_IMM;
      end else if (r < 42) begin
         op = OP_STORE;
         if (r < 34)
            xy = 8'h00;
      end else if (r < 50) begin
         op = OP_MOVE;
      end else if (r < 60) begin
         op = OP_ADD_INT;
      end else if (r < 68) begin
         op = OP_ADD_FIX;
      end else if (r < 80) begin
         op = OP_JUMP;
         if (r < 74)
            ra = 4'h0;
      end else if (r < 90) begin
         do begin
            op = 4'($urandom_range(0, 15));
            case (op)
               OP_LOAD_MEM, OP_LOAD_IMM, OP_STORE, OP_MOVE, OP_ADD_INT, OP_ADD_FIX,
               OP_JUMP, OP_HALT: defined = 1'b1;
               default: defined = 1'b0;
            endcase
         end while (defined);
      end else begin
         w = 16'($urandom_range(0, 16'hFFFF));
         if (mach_exec && w[15:12] == OP_HALT)
            w[15:12] = OP_MOVE;
         return w;
      end
      return {op, ra, xy};
   endfunction

   function automatic void add_req(input logic [15:0] w);
      plan_row_type row;
      row.kind = ROW_REQ;
      row.csr_idx = 1'b0;
      row.value = w;
      row.typed = 1'b0;
      row.want = '0;
      plan.push_back(row);
   endfunction

   function automatic void add_checked(input logic [15:0] w, input logic [1:0] st,
                                       input logic [7:0] p, input logic ov,
                                       input logic [7:0] oval);
      plan_row_type row;
      row.kind = ROW_REQ;
      row.csr_idx = 1'b0;
      row.value = w;
      row.typed = 1'b1;
      row.want = '{status: st, pointer_after: p, output_valid: ov, output_value: oval};
      plan.push_back(row);
   endfunction

   function automatic void add_csr(input logic idx, input logic [15:0] v);
      plan_row_type row;
      row.kind = ROW_CSR;
      row.csr_idx = idx;
      row.value = v;
      row.typed = 1'b0;
      row.want = '0;
      plan.push_back(row);
   endfunction

   task automatic send_request(input logic [15:0] w, input logic typed,
                               input outcome_type want);
      outcome_type predicted;
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.instruction_word <= w;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      predicted = execute_word(w);
      pending_outcomes.push_back(typed ? want : predicted);
      requests_sent++;
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] value);
      logic [31:0] mask;
      mask = (idx == CSR_IDX_START) ? 32'h0000_00FF : 32'h0000_0001;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      if (idx == CSR_IDX_START) begin
         mach_ptr = {1'b0, value[7:0]};
      end else begin
         mach_exec = value[0];
      end
      csr_writes++;
      @(negedge clock);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      if ((csr_prdata & mask) != (value & mask))
         report_mismatch($sformatf("register %0d reads %h, wrote %h", idx, csr_prdata, value));
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Response side: random stalls plus one long hold-off when asked for.
   initial begin
      int hold_left;
      int holds_seen;
      hold_left = 0;
      holds_seen = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_seen != long_holds_asked) begin
            holds_seen = long_holds_asked;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         status_seen[rsp_bus.status]++;
         if (rsp_bus.output_valid)
            zero_stores++;
         if (pending_outcomes.size() == 0) begin
            report_mismatch("response arrived with nothing expected");
         end else begin
            head = pending_outcomes.pop_front();
            if (rsp_bus.status !== head.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_bus.status, head.status));
            if (rsp_bus.pointer_after !== head.pointer_after)
               report_mismatch($sformatf("pointer_after %h, expected %h",
                                         rsp_bus.pointer_after, head.pointer_after));
            if (rsp_bus.output_valid !== head.output_valid)
               report_mismatch($sformatf("output_valid %b, expected %b",
                                         rsp_bus.output_valid, head.output_valid));
            if (rsp_bus.output_value !== head.output_value)
               report_mismatch($sformatf("output_value %h, expected %h",
                                         rsp_bus.output_value, head.output_value));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d responses outstanding.", pending_outcomes.size());
         $display("tb_simple_machine_load_and_step: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [15:0] w;
      logic [7:0]  start_pick;
      int          stop_path;
      int          n;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.instruction_word = 16'h0000;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = 32'h0;
      reset_machine();

      add_checked({OP_STORE, 12'h000}, ST_ACCEPTED, 8'h02, 1'b1, 8'h00);
      add_checked({OP_LOAD_IMM, 12'h1FF}, ST_ACCEPTED, 8'h04, 1'b0, 8'h00);
      add_checked({OP_STORE, 12'h100}, ST_ACCEPTED, 8'h06, 1'b1, 8'hFF);
      add_checked({OP_LOAD_IMM, 12'hA7F}, ST_ACCEPTED, 8'h08, 1'b0, 8'h00);
      add_req({OP_ADD_INT, 12'hBA1});
      add_req({OP_ADD_FIX, 12'hC1A});
      add_req({OP_MOVE, 12'hFBD});
      add_req({OP_STORE, 12'hD00});
      add_req({OP_LOAD_MEM, 12'hE00});
      add_req({OP_STORE, 12'hEFF});
      add_req({OP_LOAD_MEM, 12'hFFF});
      add_req({OP_STORE, 12'hF00});
      add_req(16'h0000);
      add_req(16'hFFFF);
      add_req(16'h7ABC);
      add_req({OP_JUMP, 12'h120});
      add_req({OP_JUMP, 12'h080});
      add_checked({OP_JUMP, 12'h07F}, ST_ACCEPTED, 8'hFE, 1'b0, 8'h00);
      add_checked({OP_LOAD_IMM, 12'h255}, ST_ACCEPTED, 8'h00, 1'b0, 8'h00);
      add_csr(CSR_IDX_START, 16'h0040);
      add_csr(CSR_IDX_EXEC, 16'h0000);
      add_checked({OP_HALT, 12'h000}, ST_ACCEPTED, 8'h42, 1'b0, 8'h00);
      add_checked({OP_STORE, 12'h100}, ST_ACCEPTED, 8'h44, 1'b0, 8'h00);
      add_checked(16'h8000, ST_ACCEPTED, 8'h46, 1'b0, 8'h00);
      add_csr(CSR_IDX_EXEC, 16'h0001);
      add_csr(CSR_IDX_START, 16'h0000);
      add_req({OP_LOAD_MEM, 12'h000});

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            wait_drained();
            write_csr(plan[i].csr_idx, {16'h0, plan[i].value});
         end else begin
            send_request(plan[i].value, plan[i].typed, plan[i].want);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_drained();
         case (ph)
            0: start_pick = 8'h00;
            1: start_pick = 8'hFE;
            2: start_pick = 8'($urandom_range(0, 8'h40));
            default: start_pick = 8'($urandom_range(0, 8'hFD));
         endcase
         write_csr(CSR_IDX_START, {24'h0, start_pick});
         write_csr(CSR_IDX_EXEC, (ph == 2) ? 32'h0 : {31'h0, $urandom_range(0, 9) != 0});
         idle_pct = (ph == 1 || ph == 4) ? 0 : 21;
         if (ph == 4)
            long_holds_asked++;
         n = 0;
         while (n < PHASE_REQUESTS && int'(mach_ptr) + 1 < MEM_BYTES) begin
            send_request(pick_word(), 1'b0, '0);
            n++;
         end
      end

      // Close with a stop: a halt, a start at the last byte, or a run past the end.
      idle_pct = 21;
      wait_drained();
      write_csr(CSR_IDX_EXEC, 32'h1);
      stop_path = $urandom_range(0, 2);
      write_csr(CSR_IDX_START, (stop_path == 1) ? 32'hFF : 32'h20);
      if (stop_path == 0) begin
         w = 16'($urandom_range(0, 16'hFFFF));
         w[15:12] = OP_HALT;
         send_request(w, 1'b0, '0);
      end else if (stop_path == 2) begin
         send_request({OP_JUMP, 12'h07F}, 1'b0, '0);
         send_request({OP_LOAD_IMM, 12'h3A5}, 1'b0, '0);
      end
      repeat (6) send_request(16'($urandom_range(0, 16'hFFFF)), 1'b0, '0);

      wait_drained();
      repeat (8) @(posedge clock);
      $display("Ran %0d requests and %0d register writes; %0d stores reached address zero.",
               requests_sent, csr_writes, zero_stores);
      $display("Responses by status: accepted %0d, halted %0d, memory full %0d, ignored %0d.",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (error_count == 0) begin
         $display("tb_simple_machine_load_and_step: clean");
      end else begin
         $display("tb_simple_machine_load_and_step: errors");
      end
      $finish;
   end

endmodule
